FILE: hw/rtl/dvrt_pkg.sv
// shared types and constants of the distance-vector route table
`timescale 1ns / 1ps
package dvrt_pkg;

  localparam int DIST_BITS = 24;
  localparam int ID_BITS   = 8;
  localparam int COST_BITS = 16;

  localparam logic [DIST_BITS-1:0] INF_DIST = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] MAX_FIN  = {{(DIST_BITS-1){1'b1}}, 1'b0};

  localparam logic [1:0] FUNC_ADVERT = 2'd0;
  localparam logic [1:0] FUNC_LINK   = 2'd1;
  localparam logic [1:0] FUNC_DOWN   = 2'd2;
  localparam logic [1:0] FUNC_LOOKUP = 2'd3;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [ID_BITS-1:0]   succ;
    logic                 valid;
    logic                 mark;
  } route_t;

endpackage

FILE: hw/rtl/dvrt_ifs.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface dvrt_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic [dvrt_pkg::ID_BITS-1:0]   from_node;
  logic [dvrt_pkg::ID_BITS-1:0]   dest_node;
  logic [dvrt_pkg::DIST_BITS-1:0] advertised_distance;
  logic [dvrt_pkg::COST_BITS-1:0] link_cost;
  logic                           link_up;

  modport source (output valid, func, from_node, dest_node, advertised_distance, link_cost,
                  link_up, input ready);
  modport sink (input valid, func, from_node, dest_node, advertised_distance, link_cost,
                link_up, output ready);
endinterface

interface dvrt_out_if;
  logic                           valid;
  logic                           ready;
  logic [dvrt_pkg::DIST_BITS-1:0] route_distance;
  logic [dvrt_pkg::ID_BITS-1:0]   route_next_hop;
  logic                           route_valid;
  logic [dvrt_pkg::DIST_BITS-1:0] forward_distance;
  logic                           table_changed;

  modport source (output valid, route_distance, route_next_hop, route_valid,
                  forward_distance, table_changed, input ready);
  modport sink (input valid, route_distance, route_next_hop, route_valid,
                forward_distance, table_changed, output ready);
endinterface

FILE: hw/rtl/dvrt_table_mem.sv
// per-destination route memory, one read and one write port
`timescale 1ns / 1ps
module dvrt_table_mem #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output dvrt_pkg::route_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  dvrt_pkg::route_t wr_data
);

  dvrt_pkg::route_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/dvrt_cost_mem.sv
// per-neighbor link cost memory
`timescale 1ns / 1ps
module dvrt_cost_mem #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [dvrt_pkg::COST_BITS-1:0] rd_data,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [dvrt_pkg::COST_BITS-1:0] wr_data
);

  logic [dvrt_pkg::COST_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/distance_vector_route_table.sv
// distance-vector route table: control, update logic and memories
// advertised entry, link set, lookup: READ and CALC states, then DONE registers the result
// neighbor down: sweeps the route memory entry by entry, then DONE registers the result
// one word at a time; route memory read-modify-write goes through one port pair
// reset and every my_node_id write start a clearing pass over every entry, input held off
// link costs are kept across reset and my_node_id writes
`timescale 1ns / 1ps
module distance_vector_route_table #(
  parameter int NODE_COUNT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [dvrt_pkg::ID_BITS-1:0] cfg_write_data,
  dvrt_in_if.sink                      in_ch,
  dvrt_out_if.source                   out_ch
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int DW = dvrt_pkg::DIST_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(NODE_COUNT - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  function automatic logic [IW-1:0] idx_of(input logic [dvrt_pkg::ID_BITS-1:0] id);
    return IW'(id);
  endfunction

  logic [2:0]                     state;
  logic [dvrt_pkg::ID_BITS-1:0]   my_id;
  logic [IW-1:0]                  cnt;
  logic                           issue_done;
  logic                           pend;
  logic [IW-1:0]                  pend_idx;

  logic [1:0]                     op_func;
  logic [dvrt_pkg::ID_BITS-1:0]   op_from;
  logic [dvrt_pkg::ID_BITS-1:0]   op_node;
  logic [DW-1:0]                  op_adv;
  logic [dvrt_pkg::COST_BITS-1:0] op_cost;
  logic                           op_up;
  logic [DW-1:0]                  sum_reg;
  dvrt_pkg::route_t               entry_reg;

  logic [DW-1:0]                  res_dist;
  logic [dvrt_pkg::ID_BITS-1:0]   res_hop;
  logic                           res_valid;
  logic [DW-1:0]                  res_fwd;
  logic                           res_chg;

  logic                           accept;
  logic [dvrt_pkg::ID_BITS-1:0]   in_node;
  logic                           in_ok;

  logic                           tbl_rd_en;
  logic [IW-1:0]                  tbl_rd_addr;
  dvrt_pkg::route_t               tbl_rd_data;
  logic                           tbl_wr_en;
  logic [IW-1:0]                  tbl_wr_addr;
  dvrt_pkg::route_t               tbl_wr_data;
  logic                           cost_wr_en;
  logic [dvrt_pkg::COST_BITS-1:0] cost_rd_data;

  logic [DW:0]                    sum_full;
  logic [DW-1:0]                  sum_sat;
  logic                           adv_inf;
  dvrt_pkg::route_t               calc_new;
  logic                           calc_chg;
  logic [DW-1:0]                  calc_fwd;
  dvrt_pkg::route_t               sw_new;
  logic                           sw_kill;
  logic                           sw_chg;
  dvrt_pkg::route_t               clr_entry;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_node  = (in_ch.func == dvrt_pkg::FUNC_ADVERT || in_ch.func == dvrt_pkg::FUNC_LOOKUP)
                    ? in_ch.dest_node : in_ch.from_node;
  assign in_ok    = (32'(in_node) < 32'(NODE_COUNT)) && (32'(in_ch.from_node) < 32'(NODE_COUNT));

  assign tbl_rd_en   = accept || (state == ST_SWEEP && !issue_done);
  assign tbl_rd_addr = (state == ST_SWEEP) ? cnt : idx_of(in_node);

  dvrt_table_mem #(.DEPTH(NODE_COUNT)) u_table (
    .clk     (clk),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data)
  );

  assign cost_wr_en = (state == ST_CALC) && (op_func == dvrt_pkg::FUNC_LINK);

  dvrt_cost_mem #(.DEPTH(NODE_COUNT)) u_cost (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (idx_of(in_ch.from_node)),
    .rd_data (cost_rd_data),
    .wr_en   (cost_wr_en),
    .wr_addr (idx_of(op_from)),
    .wr_data (op_cost)
  );

  // saturating sum of advertised distance and link cost
  assign sum_full = (DW + 1)'(op_adv) + (DW + 1)'(cost_rd_data);
  assign sum_sat  = (sum_full > (DW + 1)'(dvrt_pkg::MAX_FIN)) ? dvrt_pkg::MAX_FIN
                    : sum_full[DW-1:0];
  assign adv_inf  = (op_adv == dvrt_pkg::INF_DIST);

  always_comb begin
    calc_new = entry_reg;
    calc_chg = 1'b0;
    calc_fwd = '0;
    unique case (op_func)
      dvrt_pkg::FUNC_ADVERT: begin
        calc_new.mark = 1'b1;
        if (op_node != my_id) begin
          if (adv_inf) begin
            if (op_from == entry_reg.succ && entry_reg.valid) begin
              calc_new.valid    = 1'b0;
              calc_new.distance = dvrt_pkg::INF_DIST;
              calc_chg          = 1'b1;
            end
          end else if (sum_reg < entry_reg.distance ||
                       (sum_reg != entry_reg.distance && entry_reg.succ == op_from)) begin
            calc_new.distance = sum_reg;
            calc_new.succ     = op_from;
            calc_new.valid    = 1'b1;
            calc_chg          = 1'b1;
          end else if (sum_reg == entry_reg.distance && op_from < entry_reg.succ) begin
            calc_new.succ  = op_from;
            calc_new.valid = 1'b1;
            calc_chg       = 1'b1;
          end
        end
        if (adv_inf) begin
          calc_fwd = dvrt_pkg::INF_DIST;
        end else if (calc_new.valid) begin
          calc_fwd = sum_reg;
        end else begin
          calc_fwd = op_adv;
        end
      end
      dvrt_pkg::FUNC_LINK: begin
        if (op_up) begin
          calc_new.mark = 1'b1;
          if (op_node != my_id) begin
            if (sum_reg < entry_reg.distance) begin
              calc_new.distance = sum_reg;
              calc_new.succ     = op_from;
              calc_new.valid    = 1'b1;
              calc_chg          = 1'b1;
            end else if (sum_reg == entry_reg.distance && op_from < entry_reg.succ) begin
              calc_new.succ  = op_from;
              calc_new.valid = 1'b1;
              calc_chg       = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // neighbor-down kill of one swept entry
  always_comb begin
    sw_kill = (32'(pend_idx) != 32'(my_id)) &&
              (pend_idx == idx_of(op_from) || tbl_rd_data.succ == op_from);
    sw_new  = tbl_rd_data;
    if (sw_kill) begin
      sw_new.distance = dvrt_pkg::INF_DIST;
      sw_new.valid    = 1'b0;
    end
    sw_chg = sw_kill && (tbl_rd_data.valid || tbl_rd_data.distance != dvrt_pkg::INF_DIST);
  end

  always_comb begin
    clr_entry.distance = dvrt_pkg::INF_DIST;
    clr_entry.succ     = my_id;
    clr_entry.valid    = 1'b0;
    clr_entry.mark     = 1'b0;
    if (32'(cnt) == 32'(my_id)) begin
      clr_entry.distance = '0;
      clr_entry.valid    = 1'b1;
      clr_entry.mark     = 1'b1;
    end
  end

  always_comb begin
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = cnt;
    tbl_wr_data = clr_entry;
    unique case (state)
      ST_CLEAR: begin
        tbl_wr_en = 1'b1;
      end
      ST_CALC: begin
        tbl_wr_en   = (op_func == dvrt_pkg::FUNC_ADVERT) ||
                      (op_func == dvrt_pkg::FUNC_LINK && op_up);
        tbl_wr_addr = idx_of(op_node);
        tbl_wr_data = calc_new;
      end
      ST_SWEEP: begin
        tbl_wr_en   = pend;
        tbl_wr_addr = pend_idx;
        tbl_wr_data = sw_new;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      my_id      <= '0;
      cnt        <= '0;
      issue_done <= 1'b0;
      pend       <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (cfg_write_en) begin
      my_id <= cfg_write_data;
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != ST_DONE) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (!in_ok) begin
              state <= ST_DONE;
            end else if (in_ch.func == dvrt_pkg::FUNC_DOWN) begin
              state      <= ST_SWEEP;
              cnt        <= '0;
              issue_done <= 1'b0;
              pend       <= 1'b0;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          state <= ST_DONE;
        end
        ST_SWEEP: begin
          pend     <= !issue_done;
          pend_idx <= cnt;
          if (!issue_done) begin
            cnt <= cnt + 1'b1;
            if (cnt == LAST_IDX) begin
              issue_done <= 1'b1;
            end
          end
          if (pend && pend_idx == LAST_IDX) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
          cnt   <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func <= in_ch.func;
      op_from <= in_ch.from_node;
      op_node <= in_node;
      op_adv  <= in_ch.advertised_distance;
      op_cost <= in_ch.link_cost;
      op_up   <= in_ch.link_up;
      res_fwd <= '0;
      res_chg <= 1'b0;
      if (!in_ok) begin
        res_dist  <= dvrt_pkg::INF_DIST;
        res_hop   <= '0;
        res_valid <= 1'b0;
      end
    end
    if (state == ST_READ) begin
      entry_reg <= tbl_rd_data;
      sum_reg   <= (op_func == dvrt_pkg::FUNC_LINK) ? DW'(op_cost) : sum_sat;
    end
    if (state == ST_CALC) begin
      res_dist  <= calc_new.distance;
      res_hop   <= calc_new.succ;
      res_valid <= calc_new.valid;
      res_fwd   <= calc_fwd;
      res_chg   <= calc_chg;
    end
    if (state == ST_SWEEP && pend) begin
      res_chg <= res_chg | sw_chg;
      if (pend_idx == idx_of(op_from)) begin
        res_dist  <= sw_new.distance;
        res_hop   <= sw_new.succ;
        res_valid <= sw_new.valid;
      end
    end
    if (state == ST_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.route_distance   <= res_dist;
      out_ch.route_next_hop   <= res_hop;
      out_ch.route_valid      <= res_valid;
      out_ch.forward_distance <= res_fwd;
      out_ch.table_changed    <= res_chg;
    end
  end

`ifndef SYNTHESIS
  a_own_entry_fixed: assert property (@(posedge clk) disable iff (rst)
    (tbl_wr_en && 32'(tbl_wr_addr) == 32'(my_id)) |->
      (tbl_wr_data.distance == '0 && tbl_wr_data.valid))
    else $error("own route entry written with nonzero distance or invalid hop");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_write_en) |=> (state != ST_IDLE))
    else $error("accepted word did not start processing");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> ($past(state) == ST_DONE))
    else $error("result word raised outside the done state");

  a_sweep_write_in_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && pend && !issue_done) |-> (cnt == pend_idx + 1'b1))
    else $error("sweep write index does not trail read index by one");
`endif

endmodule

FILE: sim/distance_vector_route_table_checker.sv
// route table checker: watches both channels, predicts each result and compares
`timescale 1ns / 1ps
module distance_vector_route_table_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write_en,
  input  logic [dvrt_pkg::ID_BITS-1:0] cfg_write_data,
  dvrt_in_if   in_mon,
  dvrt_out_if  out_mon,
  output int   fail_count,
  output int   words_pending,
  output int   words_checked
);

  typedef struct packed {
    logic [dvrt_pkg::DIST_BITS-1:0] distance;
    logic [dvrt_pkg::ID_BITS-1:0]   hop;
    logic                           hop_ok;
    logic [dvrt_pkg::DIST_BITS-1:0] fwd;
    logic                           changed;
  } route_word_t;

  logic [dvrt_pkg::DIST_BITS-1:0] dist_tab [256];
  logic [dvrt_pkg::ID_BITS-1:0]   succ_tab [256];
  logic                           hop_tab  [256];
  logic [dvrt_pkg::DIST_BITS-1:0] cost_tab [256];
  logic [dvrt_pkg::ID_BITS-1:0]   own_id;
  route_word_t                    route_q [$];

  function automatic logic [dvrt_pkg::DIST_BITS-1:0] sat_sum(
      logic [dvrt_pkg::DIST_BITS-1:0] a, logic [dvrt_pkg::DIST_BITS-1:0] b);
    logic [dvrt_pkg::DIST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, dvrt_pkg::MAX_FIN}) ? dvrt_pkg::MAX_FIN : s[dvrt_pkg::DIST_BITS-1:0];
  endfunction

  task automatic clear_routes(logic [dvrt_pkg::ID_BITS-1:0] id);
    own_id = id;
    for (int i = 0; i < 256; i++) begin
      dist_tab[i] = dvrt_pkg::INF_DIST;
      succ_tab[i] = id;
      hop_tab[i]  = 1'b0;
    end
    dist_tab[id] = '0;
    hop_tab[id]  = 1'b1;
  endtask

  task automatic drop_route(int k, inout logic chg);
    if (k != own_id) begin
      if (hop_tab[k] || dist_tab[k] != dvrt_pkg::INF_DIST) chg = 1'b1;
      hop_tab[k]  = 1'b0;
      dist_tab[k] = dvrt_pkg::INF_DIST;
    end
  endtask

  task automatic update_route(output route_word_t r);
    logic [1:0]                     f;
    logic [dvrt_pkg::ID_BITS-1:0]   src, dst, node;
    logic [dvrt_pkg::DIST_BITS-1:0] adv, c, s, d, fwd;
    logic                           chg;
    f = in_mon.func; src = in_mon.from_node; dst = in_mon.dest_node;
    adv = in_mon.advertised_distance;
    node = (f == dvrt_pkg::FUNC_ADVERT || f == dvrt_pkg::FUNC_LOOKUP) ? dst : src;
    fwd = '0; chg = 1'b0;
    case (f)
      dvrt_pkg::FUNC_ADVERT: begin
        c = cost_tab[src];
        if (dst != own_id) begin
          if (adv == dvrt_pkg::INF_DIST) begin
            if (src == succ_tab[dst] && hop_tab[dst]) begin
              hop_tab[dst] = 1'b0; dist_tab[dst] = dvrt_pkg::INF_DIST; chg = 1'b1;
            end
          end else begin
            s = sat_sum(adv, c);
            d = dist_tab[dst];
            if (s < d || (s != d && succ_tab[dst] == src)) begin
              dist_tab[dst] = s; succ_tab[dst] = src; hop_tab[dst] = 1'b1; chg = 1'b1;
            end else if (s == d && src < succ_tab[dst]) begin
              succ_tab[dst] = src; hop_tab[dst] = 1'b1; chg = 1'b1;
            end
          end
        end
        if (adv == dvrt_pkg::INF_DIST) fwd = dvrt_pkg::INF_DIST;
        else if (hop_tab[dst]) fwd = sat_sum(adv, c);
        else fwd = adv;
      end
      dvrt_pkg::FUNC_LINK: begin
        c = {{(dvrt_pkg::DIST_BITS-dvrt_pkg::COST_BITS){1'b0}}, in_mon.link_cost};
        if (c > dvrt_pkg::MAX_FIN) c = dvrt_pkg::MAX_FIN;
        cost_tab[src] = c;
        if (in_mon.link_up && src != own_id) begin
          if (c < dist_tab[src]) begin
            dist_tab[src] = c; succ_tab[src] = src; hop_tab[src] = 1'b1; chg = 1'b1;
          end else if (c == dist_tab[src] && src < succ_tab[src]) begin
            succ_tab[src] = src; hop_tab[src] = 1'b1; chg = 1'b1;
          end
        end
      end
      dvrt_pkg::FUNC_DOWN: begin
        drop_route(src, chg);
        for (int k = 0; k < 256; k++)
          if (succ_tab[k] == src) drop_route(k, chg);
      end
      default: ;
    endcase
    r.distance = dist_tab[node]; r.hop = succ_tab[node]; r.hop_ok = hop_tab[node];
    r.fwd = fwd; r.changed = chg;
  endtask

  initial begin
    fail_count = 0;
    words_checked = 0;
    words_pending = 0;
    for (int i = 0; i < 256; i++) cost_tab[i] = '0;
    clear_routes('0);
  end

  always @(posedge clk) begin
    route_word_t e, a;
    if (rst) begin
      clear_routes('0);
      route_q.delete();
    end else begin
      if (cfg_write_en) clear_routes(cfg_write_data);
      if (in_mon.valid && in_mon.ready) begin
        update_route(e);
        route_q.push_back(e);
      end
      if (out_mon.valid && out_mon.ready) begin
        a.distance = out_mon.route_distance; a.hop = out_mon.route_next_hop;
        a.hop_ok = out_mon.route_valid; a.fwd = out_mon.forward_distance;
        a.changed = out_mon.table_changed;
        words_checked++;
        if (route_q.size() == 0) begin
          fail_count++;
          $display("%t unexpected word: actual %h", $time, a);
        end else begin
          e = route_q.pop_front();
          if (a.distance !== e.distance) begin
            fail_count++;
            $display("%t route_distance expected %h actual %h", $time, e.distance,
                     a.distance);
          end
          if (a.hop !== e.hop) begin
            fail_count++;
            $display("%t route_next_hop expected %h actual %h", $time, e.hop, a.hop);
          end
          if (a.hop_ok !== e.hop_ok) begin
            fail_count++;
            $display("%t route_valid expected %b actual %b", $time, e.hop_ok, a.hop_ok);
          end
          if (a.fwd !== e.fwd) begin
            fail_count++;
            $display("%t forward_distance expected %h actual %h", $time, e.fwd, a.fwd);
          end
          if (a.changed !== e.changed) begin
            fail_count++;
            $display("%t table_changed expected %b actual %b", $time, e.changed, a.changed);
          end
        end
      end
    end
    words_pending = route_q.size();
  end
endmodule

FILE: sim/distance_vector_route_table_tb.sv
// route table testbench top: stimulus, output stalls and verdict
`timescale 1ns / 1ps
module distance_vector_route_table_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [dvrt_pkg::ID_BITS-1:0] cfg_write_data = '0;
  int fail_count, words_pending, words_checked;
  int words_sent = 0;
  int id_settings = 1;
  bit quiet = 1'b0;
  logic [dvrt_pkg::ID_BITS-1:0] nbr_pool [8] =
    '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd128, 8'd254, 8'd255};
  int out_stall = 0;

  dvrt_in_if  in_ch ();
  dvrt_out_if out_ch ();

  distance_vector_route_table dut (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  distance_vector_route_table_checker route_chk (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_mon(in_ch), .out_mon(out_ch), .fail_count(fail_count),
    .words_pending(words_pending), .words_checked(words_checked)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0; in_ch.func = dvrt_pkg::FUNC_LOOKUP; in_ch.from_node = '0;
    in_ch.dest_node = '0; in_ch.advertised_distance = '0; in_ch.link_cost = '0;
    in_ch.link_up = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (quiet || rst) begin
      out_ch.ready = 1'b1;
    end else if (out_stall > 0) begin
      out_ch.ready = 1'b0;
      out_stall--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready = 1'b0;
      out_stall = $urandom_range(0, 2);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic send_word(logic [1:0] f, logic [dvrt_pkg::ID_BITS-1:0] src,
                           logic [dvrt_pkg::ID_BITS-1:0] dst,
                           logic [dvrt_pkg::DIST_BITS-1:0] adv,
                           logic [dvrt_pkg::COST_BITS-1:0] cost, logic up);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func = f; in_ch.from_node = src; in_ch.dest_node = dst;
    in_ch.advertised_distance = adv; in_ch.link_cost = cost; in_ch.link_up = up;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_own_id(logic [dvrt_pkg::ID_BITS-1:0] id);
    drain();
    cfg_write_data = id;
    cfg_write_en = 1'b1;
    @(negedge clk);
    cfg_write_en = 1'b0;
    id_settings++;
  endtask

  function automatic logic [dvrt_pkg::ID_BITS-1:0] pick_dest();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(0, 15));
    if (r < 8) return nbr_pool[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [dvrt_pkg::DIST_BITS-1:0] pick_adv();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return dvrt_pkg::INF_DIST;
    if (r < 3) return dvrt_pkg::MAX_FIN - 24'($urandom_range(0, 3));
    if (r < 4) return 24'($urandom_range(0, 24'hFFFFFF));
    return 24'($urandom_range(0, 40));
  endfunction

  task automatic random_items(int n);
    int r;
    logic [dvrt_pkg::ID_BITS-1:0] src;
    logic [dvrt_pkg::COST_BITS-1:0] cost;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      src = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                        : nbr_pool[$urandom_range(0, 7)];
      if (r < 50) begin
        src = nbr_pool[$urandom_range(0, 7)];
        send_word(dvrt_pkg::FUNC_ADVERT, src, pick_dest(), pick_adv(), 16'($urandom),
                  1'($urandom));
      end else if (r < 70) begin
        case ($urandom_range(0, 9))
          0: cost = '0;
          1: cost = '1;
          2: cost = 16'($urandom);
          default: cost = 16'($urandom_range(1, 20));
        endcase
        send_word(dvrt_pkg::FUNC_LINK, src, 8'($urandom), 24'($urandom), cost,
                  $urandom_range(0, 3) != 0);
      end else if (r < 78) begin
        send_word(dvrt_pkg::FUNC_DOWN, src, 8'($urandom), 24'($urandom), 16'($urandom),
                  1'($urandom));
      end else begin
        send_word(dvrt_pkg::FUNC_LOOKUP, 8'($urandom), pick_dest(), 24'($urandom),
                  16'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // neighbor links, including a down link and the own id
    send_word(dvrt_pkg::FUNC_LINK, 8'd1, '0, '0, 16'd5, 1'b1);
    send_word(dvrt_pkg::FUNC_LINK, 8'd2, '0, '0, 16'd0, 1'b1);
    send_word(dvrt_pkg::FUNC_LINK, 8'd3, '0, '0, 16'hFFFF, 1'b1);
    send_word(dvrt_pkg::FUNC_LINK, 8'd4, '0, '0, 16'd10, 1'b0);
    send_word(dvrt_pkg::FUNC_LINK, 8'd0, '0, '0, 16'd7, 1'b1);
    send_word(dvrt_pkg::FUNC_LINK, 8'd128, '0, '0, 16'd3, 1'b1);
    send_word(dvrt_pkg::FUNC_LINK, 8'd254, '0, '0, 16'd1, 1'b1);
    send_word(dvrt_pkg::FUNC_LINK, 8'd255, '0, '0, 16'd2, 1'b1);
    // relaxation, ties, cost rise, poison, saturation
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd1, 8'd50, 24'd10, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd2, 8'd50, 24'd15, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd2, 8'd70, 24'd20, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd1, 8'd70, 24'd15, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd1, 8'd50, 24'd100, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd1, 8'd50, dvrt_pkg::INF_DIST, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd3, 8'd80, dvrt_pkg::MAX_FIN, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd1, 8'd0, 24'd0, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd255, 8'd255, 24'd0, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_ADVERT, 8'd4, 8'd90, 24'd5, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_LOOKUP, 8'd0, 8'd70, '0, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_LOOKUP, 8'd0, 8'd0, '0, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_DOWN, 8'd1, 8'd0, '0, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_LOOKUP, 8'd0, 8'd70, '0, '0, 1'b0);
    send_word(dvrt_pkg::FUNC_DOWN, 8'd0, 8'd0, '0, '0, 1'b0);

    random_items(190);
    set_own_id(8'd255);
    random_items(180);
    set_own_id(8'd3);
    random_items(180);
    set_own_id(8'($urandom));
    random_items(180);
    set_own_id(8'd0);
    quiet = 1'b1;
    random_items(200);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("sent %0d words over %0d node id settings, %0d results checked",
             words_sent, id_settings, words_checked);
    $display("covered advertise, link set, neighbor down and lookup with stalls on both sides");
    if (fail_count == 0) begin
      $display("PASS distance_vector_route_table");
    end else begin
      $display("FAIL distance_vector_route_table");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL distance_vector_route_table");
    $finish;
  end
endmodule
